// File: rtl/tpls_pkg.sv
// Package for the text page layout scanner: request and result structs,
// held-byte kinds, register indexes, character codes and reset values.
// No dependencies.
package tpls_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_AREA_LEFT    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_AREA_TOP     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_AREA_WIDTH   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_AREA_HEIGHT  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GLYPH_HEIGHT = 3'd4;

    // Register reset values
    localparam int RST_AREA_LEFT    = 2;
    localparam int RST_AREA_TOP     = 26;
    localparam int RST_AREA_WIDTH   = 236;
    localparam int RST_AREA_HEIGHT  = 256;
    localparam int RST_GLYPH_HEIGHT = 16;

    localparam int GLYPH_BITS = 6;

    // Character codes
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] LEAD_MIN  = 8'h81;
    localparam logic [7:0] TRAIL_MIN = 8'h40;

    // Request modes and result reasons
    localparam logic MODE_TEXT   = 1'b0;
    localparam logic MODE_EOF    = 1'b1;
    localparam logic REASON_FULL = 1'b0;
    localparam logic REASON_EOF  = 1'b1;

    typedef enum logic [1:0] {
        HELD_NONE = 2'd0,
        HELD_CR   = 2'd1,
        HELD_LEAD = 2'd2
    } held_kind_t;

    typedef struct packed {
        logic        mode;
        logic [7:0]  text_byte;
        logic [31:0] offset;
        logic        first;
    } tpls_in_t;

    typedef struct packed {
        logic [31:0] next_page_off;
        logic        reason;
    } tpls_out_t;

endpackage

// File: rtl/tpls_layout.sv
// Layout state and combinational step logic of the text page layout scanner.
// Depends on tpls_pkg.
module tpls_layout #(
    parameter int OFFSET_BITS = 32,
    parameter int COORD_BITS  = 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                item_valid,
    input  tpls_pkg::tpls_in_t                  item,
    input  logic                                step_en,
    input  logic [COORD_BITS-1:0]               area_left,
    input  logic [COORD_BITS-1:0]               area_top,
    input  logic [COORD_BITS-1:0]               area_width,
    input  logic [COORD_BITS-1:0]               area_height,
    input  logic [tpls_pkg::GLYPH_BITS-1:0]     glyph_height,
    output logic                                res_valid,
    output tpls_pkg::tpls_out_t                 res
);

    localparam int XW = COORD_BITS + 1;
    localparam int YW = COORD_BITS + 2;
    localparam int SW = COORD_BITS + 2;
    localparam int GW = tpls_pkg::GLYPH_BITS;

    typedef struct packed {
        logic [YW-1:0] y;
        logic [XW-1:0] x;
        logic          full;
    } pos_t;

    // Wrap if the glyph does not fit, then test the page bottom
    function automatic pos_t place_char(
        input logic [XW-1:0] x,
        input logic [YW-1:0] y,
        input logic [GW-1:0] w,
        input logic [XW-1:0] left,
        input logic [SW-1:0] right_edge,
        input logic [YW-1:0] lim,
        input logic [GW-1:0] pitch
    );
        pos_t p;
        p.x = x;
        p.y = y;
        if ((SW'(x) + SW'(w)) > right_edge) begin
            p.y = y + YW'(pitch);
            p.x = left;
        end
        p.full = (p.y >= lim);
        if (!p.full) begin
            p.x = p.x + XW'(w);
        end
        return p;
    endfunction

    logic [XW-1:0]        cursor_x_reg, cursor_x_next;
    logic [YW-1:0]        cursor_y_reg, cursor_y_next;
    tpls_pkg::held_kind_t held_kind_reg, held_kind_next;
    logic [OFFSET_BITS-1:0] held_offset_reg, held_offset_next;
    logic                 page_done_reg, page_done_next;

    logic [XW-1:0]        left_x;
    logic [SW-1:0]        right_edge;
    logic [YW-1:0]        lim;
    logic [GW-1:0]        half;
    logic [OFFSET_BITS-1:0] cur_off, next_off, pe;
    logic                 emit, why, cont;
    pos_t                 p;

    assign left_x     = XW'(area_left);
    assign right_edge = SW'(area_left) + SW'(area_width);
    assign lim        = YW'(area_top) + YW'(area_height);
    assign half       = glyph_height >> 1;
    assign cur_off    = OFFSET_BITS'(item.offset);
    assign next_off   = cur_off + OFFSET_BITS'(1);

    always_comb begin
        cursor_x_next    = cursor_x_reg;
        cursor_y_next    = cursor_y_reg;
        held_kind_next   = held_kind_reg;
        held_offset_next = held_offset_reg;
        page_done_next   = page_done_reg;
        emit = 1'b0;
        why  = tpls_pkg::REASON_FULL;
        pe   = '0;
        cont = 1'b1;
        p    = '0;

        if (item.first) begin
            cursor_x_next    = left_x;
            cursor_y_next    = YW'(area_top);
            held_kind_next   = tpls_pkg::HELD_NONE;
            held_offset_next = '0;
            page_done_next   = 1'b0;
        end

        if (!page_done_next) begin
            if (item.mode == tpls_pkg::MODE_EOF) begin
                if (held_kind_next == tpls_pkg::HELD_CR) begin
                    p = place_char(cursor_x_next, cursor_y_next, half, left_x,
                                   right_edge, lim, glyph_height);
                    cursor_x_next = p.x;
                    cursor_y_next = p.y;
                    if (p.full) begin
                        emit = 1'b1;
                        pe   = held_offset_next;
                    end
                end
                if (!emit) begin
                    emit = 1'b1;
                    pe   = cur_off;
                    why  = tpls_pkg::REASON_EOF;
                end
            end else begin
                // Resolve the held byte first
                if (held_kind_next == tpls_pkg::HELD_LEAD) begin
                    if (item.text_byte >= tpls_pkg::TRAIL_MIN) begin
                        p = place_char(cursor_x_next, cursor_y_next, glyph_height,
                                       left_x, right_edge, lim, glyph_height);
                        cont = 1'b0;
                    end else begin
                        p = place_char(cursor_x_next, cursor_y_next, half, left_x,
                                       right_edge, lim, glyph_height);
                    end
                    cursor_x_next = p.x;
                    cursor_y_next = p.y;
                    if (p.full) begin
                        emit = 1'b1;
                        pe   = held_offset_next;
                        cont = 1'b0;
                    end
                end else if (held_kind_next == tpls_pkg::HELD_CR) begin
                    if (item.text_byte == tpls_pkg::CHAR_LF) begin
                        cursor_y_next = cursor_y_next + YW'(glyph_height);
                        cursor_x_next = left_x;
                        cont = 1'b0;
                        if (cursor_y_next >= lim) begin
                            emit = 1'b1;
                            pe   = next_off;
                        end
                    end else begin
                        p = place_char(cursor_x_next, cursor_y_next, half, left_x,
                                       right_edge, lim, glyph_height);
                        cursor_x_next = p.x;
                        cursor_y_next = p.y;
                        if (p.full) begin
                            emit = 1'b1;
                            pe   = held_offset_next;
                            cont = 1'b0;
                        end
                    end
                end
                held_kind_next = tpls_pkg::HELD_NONE;

                // Then the byte itself
                if (cont) begin
                    if (item.text_byte == tpls_pkg::CHAR_LF) begin
                        cursor_y_next = cursor_y_next + YW'(glyph_height);
                        cursor_x_next = left_x;
                        if (cursor_y_next >= lim) begin
                            emit = 1'b1;
                            pe   = next_off;
                        end
                    end else if (item.text_byte == tpls_pkg::CHAR_CR) begin
                        held_kind_next   = tpls_pkg::HELD_CR;
                        held_offset_next = cur_off;
                    end else if (item.text_byte >= tpls_pkg::LEAD_MIN) begin
                        held_kind_next   = tpls_pkg::HELD_LEAD;
                        held_offset_next = cur_off;
                    end else begin
                        p = place_char(cursor_x_next, cursor_y_next, half, left_x,
                                       right_edge, lim, glyph_height);
                        cursor_x_next = p.x;
                        cursor_y_next = p.y;
                        if (p.full) begin
                            emit = 1'b1;
                            pe   = cur_off;
                        end
                    end
                end
            end

            if (emit) begin
                page_done_next = 1'b1;
                held_kind_next = tpls_pkg::HELD_NONE;
            end
        end
    end

    assign res_valid = item_valid && emit;
    assign res       = '{next_page_off: 32'(pe), reason: why};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_x_reg    <= XW'(tpls_pkg::RST_AREA_LEFT);
            cursor_y_reg    <= YW'(tpls_pkg::RST_AREA_TOP);
            held_kind_reg   <= tpls_pkg::HELD_NONE;
            held_offset_reg <= '0;
            page_done_reg   <= 1'b0;
        end else if (step_en) begin
            cursor_x_reg    <= cursor_x_next;
            cursor_y_reg    <= cursor_y_next;
            held_kind_reg   <= held_kind_next;
            held_offset_reg <= held_offset_next;
            page_done_reg   <= page_done_next;
        end
    end

    // A result closes the page until the next restart
    a_result_closes_page: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && res_valid) |=> page_done_reg)
        else $error("page not closed after a result");

    a_closed_page_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (page_done_reg && !item.first) |-> !res_valid)
        else $error("result from a closed page");

    a_eof_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && item.mode == tpls_pkg::MODE_EOF
         && (!page_done_reg || item.first)) |-> res_valid)
        else $error("end of file without a result");

endmodule

// File: rtl/text_page_layout_scanner.sv
// Text page layout scanner, top level: request and result registers,
// configuration registers. Depends on tpls_pkg and tpls_layout.
//
// The block takes one text byte per request, with its file offset, and
// tracks where it would land on the text area. It returns a result only
// when the page is full (the offset where the next page starts, reason 0)
// or at end of file (the file size, reason 1); after a result it stays
// silent until a request with first set restarts at the top left. Rate:
// one request per cycle when not stalled; a request is registered on
// acceptance, its layout step runs in the following cycle against the
// cursor registers, and a result is held in the output register on m_*.
// The only stall is a result waiting in the output register while
// the next request also produces one. Configuration writes are taken at
// any time on the cfg_* port (cfg_ready is always high) but must only be
// issued while the block is idle.
module text_page_layout_scanner #(
    parameter int OFFSET_BITS = 32,
    parameter int COORD_BITS  = 10
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    // request channel
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  tpls_pkg::tpls_in_t                       s_data,
    // result channel
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output tpls_pkg::tpls_out_t                      m_data,
    // configuration write channel
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [tpls_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
    input  logic [COORD_BITS-1:0]                    cfg_data
);

    localparam int GW = tpls_pkg::GLYPH_BITS;

    logic [COORD_BITS-1:0] area_left_reg, area_top_reg, area_width_reg, area_height_reg;
    logic [GW-1:0]         glyph_height_reg;

    logic                  in_valid_reg;
    tpls_pkg::tpls_in_t    in_data_reg;
    logic                  out_valid_reg;
    tpls_pkg::tpls_out_t   out_data_reg;

    logic                  res_valid;
    tpls_pkg::tpls_out_t   res;
    logic                  advance;

    // Advance the held request unless it has a result and the output is blocked
    assign advance   = in_valid_reg && (!res_valid || !out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            area_left_reg    <= COORD_BITS'(tpls_pkg::RST_AREA_LEFT);
            area_top_reg     <= COORD_BITS'(tpls_pkg::RST_AREA_TOP);
            area_width_reg   <= COORD_BITS'(tpls_pkg::RST_AREA_WIDTH);
            area_height_reg  <= COORD_BITS'(tpls_pkg::RST_AREA_HEIGHT);
            glyph_height_reg <= GW'(tpls_pkg::RST_GLYPH_HEIGHT);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                tpls_pkg::CFG_AREA_LEFT:    area_left_reg    <= cfg_data;
                tpls_pkg::CFG_AREA_TOP:     area_top_reg     <= cfg_data;
                tpls_pkg::CFG_AREA_WIDTH:   area_width_reg   <= cfg_data;
                tpls_pkg::CFG_AREA_HEIGHT:  area_height_reg  <= cfg_data;
                tpls_pkg::CFG_GLYPH_HEIGHT: glyph_height_reg <= GW'(cfg_data);
                default: ;
            endcase
        end
    end

    // Request register: hold until the layout step takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Result register: load a new result, drop one the sink has taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_data_reg <= res;
        end
    end

    tpls_layout #(
        .OFFSET_BITS (OFFSET_BITS),
        .COORD_BITS  (COORD_BITS)
    ) u_layout (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_valid   (in_valid_reg),
        .item         (in_data_reg),
        .step_en      (advance),
        .area_left    (area_left_reg),
        .area_top     (area_top_reg),
        .area_width   (area_width_reg),
        .area_height  (area_height_reg),
        .glyph_height (glyph_height_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

endmodule
